>>> hw/rtl/lsu_pkg.sv
`default_nettype none

package lsu_pkg;

	localparam int WORD_W    = 32;
	localparam int POS_W     = 7;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_POP     = 3'd1,
		OP_PEEK    = 3'd2,
		OP_CHANGE  = 3'd3,
		OP_DISPLAY = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_EMPTY    = 2'd1,
		STS_OVERFLOW = 2'd2,
		STS_BADPOS   = 2'd3
	} status_t;

	// ST_DISP drains reads: one stored word per cycle, also used for pop and peek
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DISP = 1'b1
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/lsu_ram.sv
`default_nettype none

module lsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/lifo_stack_with_update.sv
// Channel   | Signals                           | Handshake
// ----------+-----------------------------------+-----------------------------------
// request   | operation, value, position        | taken when start && !busy
// result    | word, status, last                | shown for one cycle while strobe
//
// Push, change, unknown operations and every error give their result the cycle after
// the request is taken, and a new request may follow at once.
// Pop and peek make one synchronous RAM read and hold busy in ST_DISP until it is done.
// Display of N words makes one RAM read per stored word, top first.
// Reset clears the word count and the control state; RAM contents stay as they are.
// The receiver cannot stall; results are never held back.
`default_nettype none

module lifo_stack_with_update
	import lsu_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [2:0]               operation,
	input  wire logic signed [WORD_W-1:0] value,
	input  wire logic [POS_W-1:0]         position,
	output logic                          strobe,
	output logic signed [WORD_W-1:0]      word,
	output logic [1:0]                    status,
	output logic                          last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t              state_q, state_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [AW-1:0]       idx_q, idx_d;

	logic                strobe_q, res_vld;
	logic [WORD_W-1:0]   word_q, res_word;
	status_t             status_q, res_status;
	logic                last_q, res_last;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [WORD_W-1:0]   ram_wdata, ram_rdata;

	logic                acc;
	logic                empty, full;
	logic [POS_W-1:0]    pos_eff, cnt_ext;
	logic                bad_pos;
	logic [AW-1:0]       top_addr;

	assign busy     = (state_q != ST_IDLE);
	assign acc      = start && !busy;
	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == CW'(DEPTH));
	assign pos_eff  = (position == '0) ? POS_W'(1) : position;
	assign cnt_ext  = POS_W'(cnt_q);
	assign bad_pos  = (pos_eff > cnt_ext);
	assign top_addr = AW'(cnt_q - CW'(1));

	lsu_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && !empty) begin
					case (op_t'(operation))
						OP_POP, OP_PEEK, OP_DISPLAY: state_d = ST_DISP;
						default:                     state_d = ST_IDLE;
					endcase
				end
			end
			ST_DISP: begin
				if (idx_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		ram_we     = 1'b0;
		ram_waddr  = cnt_q[AW-1:0];
		ram_wdata  = value;
		ram_raddr  = top_addr;
		res_vld    = 1'b0;
		res_word   = '0;
		res_status = STS_OK;
		res_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (op_t'(operation))
						OP_PUSH: begin
							res_vld = 1'b1;
							if (full) begin
								res_status = STS_OVERFLOW;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = AW'(cnt_q);
								cnt_d     = cnt_q + CW'(1);
							end
						end
						OP_POP: begin
							if (empty) begin
								res_vld    = 1'b1;
								res_status = STS_EMPTY;
							end else begin
								cnt_d = cnt_q - CW'(1);
								idx_d = '0;
							end
						end
						OP_PEEK: begin
							if (empty) begin
								res_vld    = 1'b1;
								res_status = STS_EMPTY;
							end else begin
								idx_d = '0;
							end
						end
						OP_CHANGE: begin
							res_vld = 1'b1;
							if (bad_pos) begin
								res_status = STS_BADPOS;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = AW'(cnt_ext - pos_eff);
							end
						end
						OP_DISPLAY: begin
							if (empty) begin
								res_vld    = 1'b1;
								res_status = STS_EMPTY;
							end else begin
								idx_d = top_addr;
							end
						end
						default: res_vld = 1'b1;
					endcase
				end
			end
			ST_DISP: begin
				// for display, idx_q is the entry whose read data arrives now (zero for pop and peek)
				res_vld   = 1'b1;
				res_word  = ram_rdata;
				res_last  = (idx_q == '0);
				ram_raddr = idx_q - AW'(1);
				if (idx_q != '0) begin
					idx_d = idx_q - AW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			strobe_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		word_q   <= res_word;
		status_q <= res_status;
		last_q   <= res_last;
	end

	assign strobe = strobe_q;
	assign word   = word_q;
	assign status = status_q;
	assign last   = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("word count beyond depth");

	// a pop lowers the count on the edge that takes it, so the count is held from then on
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !ram_we ##1 $stable(cnt_q))
		else $error("stack changed during a read sequence");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status_q != STS_OK) |-> (word_q == '0) && last_q)
		else $error("error result carries a word or is not last");

	a_disp_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DISP) && (idx_q == '0) |=> strobe && last && !busy)
		else $error("read sequence ended without a final result");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import lsu_pkg::*;

	localparam int STACK_DEPTH    = DEPTH_DEF;
	localparam int DIRECTED_ROWS  = 26;
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_REQUESTS = 115;
	localparam int CYCLE_LIMIT    = 200000;

	// operation codes the block ignores
	localparam logic [2:0] OP_RSVD_A = 3'd5;
	localparam logic [2:0] OP_RSVD_B = 3'd6;
	localparam logic [2:0] OP_RSVD_C = 3'd7;

	typedef struct {
		logic signed [WORD_W-1:0] word;
		status_t                  status;
		logic                     last;
	} stack_result_t;

	typedef struct {
		logic [2:0]               op;
		logic signed [WORD_W-1:0] value;
		logic [POS_W-1:0]         pos;
		bit                       typed;
		logic signed [WORD_W-1:0] exp_word;
		status_t                  exp_status;
	} stack_request_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [2:0]               operation;
	logic signed [WORD_W-1:0] value;
	logic [POS_W-1:0]         position;
	logic                     strobe;
	logic signed [WORD_W-1:0] word;
	logic [1:0]               status;
	logic                     last;

	// typed-in expectation that travels with the request
	logic                     typed_valid;
	logic signed [WORD_W-1:0] typed_word;
	status_t                  typed_status;

	// shadow of the stack contents
	logic signed [WORD_W-1:0] shadow_words [STACK_DEPTH];
	int unsigned              shadow_count;

	stack_result_t pending_results [$];
	stack_result_t oldest;
	int            fail_count;
	int            cycle_count;

	// driver-side fill estimate, used to steer the random mix
	int unsigned fill_level;
	bit          growing;

	lifo_stack_with_update DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.value     (value),
		.position  (position),
		.strobe    (strobe),
		.word      (word),
		.status    (status),
		.last      (last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lifo_stack_with_update verification failed");
			$finish;
		end
	end

	function automatic void queue_result(logic signed [WORD_W-1:0] w, status_t s, logic l);
		stack_result_t r;
		r.word   = w;
		r.status = s;
		r.last   = l;
		pending_results.push_back(r);
	endfunction

	function automatic void predict_stack_op(logic [2:0] op, logic signed [WORD_W-1:0] val,
			logic [POS_W-1:0] pos);
		int unsigned slot;
		int unsigned i;
		slot = (pos == 0) ? 1 : pos;
		case (op)
			OP_PUSH: begin
				if (shadow_count >= STACK_DEPTH) begin
					queue_result('0, STS_OVERFLOW, 1'b1);
				end else begin
					shadow_words[shadow_count] = val;
					shadow_count++;
					queue_result('0, STS_OK, 1'b1);
				end
			end
			OP_POP: begin
				if (shadow_count == 0) begin
					queue_result('0, STS_EMPTY, 1'b1);
				end else begin
					shadow_count--;
					queue_result(shadow_words[shadow_count], STS_OK, 1'b1);
				end
			end
			OP_PEEK: begin
				if (shadow_count == 0)
					queue_result('0, STS_EMPTY, 1'b1);
				else
					queue_result(shadow_words[shadow_count-1], STS_OK, 1'b1);
			end
			OP_CHANGE: begin
				if (slot > shadow_count) begin
					queue_result('0, STS_BADPOS, 1'b1);
				end else begin
					shadow_words[shadow_count-slot] = val;
					queue_result('0, STS_OK, 1'b1);
				end
			end
			OP_DISPLAY: begin
				if (shadow_count == 0) begin
					queue_result('0, STS_EMPTY, 1'b1);
				end else begin
					for (i = shadow_count; i > 0; i--)
						queue_result(shadow_words[i-1], STS_OK, i == 1);
				end
			end
			default: queue_result('0, STS_OK, 1'b1);
		endcase
	endfunction

	// result check first: a result always belongs to an earlier request
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("result with none pending: word %h status %0d last %b",
						word, status, last);
					fail_count++;
				end else begin
					oldest = pending_results.pop_front();
					if (word !== oldest.word) begin
						$error("word: expected %h, got %h", oldest.word, word);
						fail_count++;
					end
					if (status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, status);
						fail_count++;
					end
					if (last !== oldest.last) begin
						$error("last: expected %b, got %b", oldest.last, last);
						fail_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predict_stack_op(operation, value, position);
				if (typed_valid) begin
					void'(pending_results.pop_back());
					queue_result(typed_word, typed_status, 1'b1);
				end
			end
		end
	end

	function automatic stack_request_t req_row(logic [2:0] op, logic signed [WORD_W-1:0] v,
			logic [POS_W-1:0] p, bit t, logic signed [WORD_W-1:0] w, status_t s);
		stack_request_t r;
		r.op         = op;
		r.value      = v;
		r.pos        = p;
		r.typed      = t;
		r.exp_word   = w;
		r.exp_status = s;
		return r;
	endfunction

	function automatic stack_request_t directed_row(int idx);
		stack_request_t r;
		case (idx)
			0:  r = req_row(OP_POP,     32'sd0,           7'd0,   1, 32'sd0, STS_EMPTY);
			1:  r = req_row(OP_PEEK,    32'sd0,           7'd0,   1, 32'sd0, STS_EMPTY);
			2:  r = req_row(OP_DISPLAY, 32'sd0,           7'd0,   1, 32'sd0, STS_EMPTY);
			3:  r = req_row(OP_CHANGE,  32'sd9,           7'd0,   1, 32'sd0, STS_BADPOS);
			4:  r = req_row(OP_CHANGE,  32'sd9,           7'd127, 1, 32'sd0, STS_BADPOS);
			5:  r = req_row(OP_RSVD_C,  -32'sd1,          7'd127, 1, 32'sd0, STS_OK);
			6:  r = req_row(OP_PUSH,    32'sh7FFF_FFFF,   7'd0,   1, 32'sd0, STS_OK);
			7:  r = req_row(OP_PEEK,    32'sd0,           7'd0,   1, 32'sh7FFF_FFFF, STS_OK);
			8:  r = req_row(OP_PUSH,    32'sh8000_0000,   7'd0,   1, 32'sd0, STS_OK);
			9:  r = req_row(OP_PEEK,    32'sd0,           7'd0,   1, 32'sh8000_0000, STS_OK);
			10: r = req_row(OP_PUSH,    32'sd0,           7'd0,   1, 32'sd0, STS_OK);
			11: r = req_row(OP_PUSH,    -32'sd1,          7'd0,   1, 32'sd0, STS_OK);
			12: r = req_row(OP_DISPLAY, 32'sd0,           7'd0,   0, 32'sd0, STS_OK);
			13: r = req_row(OP_CHANGE,  32'sd5,           7'd0,   1, 32'sd0, STS_OK);
			14: r = req_row(OP_CHANGE,  32'sd6,           7'd1,   1, 32'sd0, STS_OK);
			15: r = req_row(OP_CHANGE,  32'sh1234_5678,   7'd4,   1, 32'sd0, STS_OK);
			16: r = req_row(OP_CHANGE,  32'sd7,           7'd5,   1, 32'sd0, STS_BADPOS);
			17: r = req_row(OP_CHANGE,  32'sd7,           7'd64,  1, 32'sd0, STS_BADPOS);
			18: r = req_row(OP_RSVD_A,  32'sh5555_AAAA,   7'd42,  1, 32'sd0, STS_OK);
			19: r = req_row(OP_RSVD_B,  32'shAAAA_5555,   7'd85,  1, 32'sd0, STS_OK);
			20: r = req_row(OP_DISPLAY, 32'sd0,           7'd0,   0, 32'sd0, STS_OK);
			21: r = req_row(OP_POP,     32'sd0,           7'd0,   0, 32'sd0, STS_OK);
			22: r = req_row(OP_PEEK,    32'sd0,           7'd0,   0, 32'sd0, STS_OK);
			23: r = req_row(OP_POP,     32'sd0,           7'd0,   0, 32'sd0, STS_OK);
			24: r = req_row(OP_POP,     32'sd0,           7'd0,   0, 32'sd0, STS_OK);
			default: r = req_row(OP_POP, 32'sd0,          7'd0,   0, 32'sd0, STS_OK);
		endcase
		return r;
	endfunction

	task automatic issue(input stack_request_t req);
		start        <= 1'b1;
		operation    <= req.op;
		value        <= req.value;
		position     <= req.pos;
		typed_valid  <= req.typed;
		typed_word   <= req.exp_word;
		typed_status <= req.exp_status;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (req.op == OP_PUSH && fill_level < STACK_DEPTH)
			fill_level++;
		else if (req.op == OP_POP && fill_level > 0)
			fill_level--;
	endtask

	initial begin
		stack_request_t req;
		int             idx;
		int             phase;
		int             idle_pct;
		int             pick;
		int             push_cut;
		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = '0;
		value        = '0;
		position     = '0;
		typed_valid  = 1'b0;
		typed_word   = '0;
		typed_status = STS_OK;
		shadow_count = 0;
		fill_level   = 0;
		growing      = 1'b1;
		fail_count   = 0;
		cycle_count  = 0;
		for (idx = 0; idx < STACK_DEPTH; idx++)
			shadow_words[idx] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < DIRECTED_ROWS; idx++)
			issue(directed_row(idx));

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				1:       idle_pct = 62;
				3:       idle_pct = 18;
				default: idle_pct = 0;
			endcase
			// hold off until every pending result is back
			start <= 1'b0;
			@(posedge clk);
			while (pending_results.size() != 0)
				@(posedge clk);

			for (idx = 0; idx < PHASE_REQUESTS; idx++) begin
				if (fill_level == STACK_DEPTH && $urandom_range(0, 2) == 0)
					growing = 1'b0;
				else if (fill_level == 0 && $urandom_range(0, 2) == 0)
					growing = 1'b1;
				// tide between filling and draining so full and empty both get hit
				push_cut = growing ? 65 : 8;
				pick = $urandom_range(0, 99);
				req.typed      = 0;
				req.exp_word   = '0;
				req.exp_status = STS_OK;
				if (pick < push_cut)
					req.op = OP_PUSH;
				else if (pick < 73)
					req.op = OP_POP;
				else if (pick < 81)
					req.op = OP_PEEK;
				else if (pick < 93)
					req.op = OP_CHANGE;
				else if (pick < 98)
					req.op = OP_DISPLAY;
				else
					req.op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
				case ($urandom_range(0, 7))
					0:       req.value = 32'sh7FFF_FFFF;
					1:       req.value = 32'sh8000_0000;
					2:       req.value = '0;
					default: req.value = $urandom;
				endcase
				if (req.op == OP_CHANGE && $urandom_range(0, 4) != 0)
					req.pos = POS_W'($urandom_range(0, fill_level));
				else
					req.pos = POS_W'($urandom_range(0, 127));
				if ($urandom_range(1, 100) <= idle_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
				issue(req);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (STACK_DEPTH + 4) @(posedge clk);
		if (fail_count == 0)
			$display("lifo_stack_with_update verification clean");
		else
			$display("lifo_stack_with_update verification failed");
		$finish;
	end

endmodule
